>>> rtl/srib_pkg.sv
// Shared types and constants for the sorted record insertion buffer.
// Used by every module of the block; depends on nothing.
package srib_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam int KEY_W  = 16;
    localparam int DIST_W = 16;
    localparam int PROT_W = 8;
    localparam int CYC_W  = 12;
    localparam int POS_W  = 8;
    localparam int ECNT_W = 9;
    localparam int ARR_W  = 9;
    localparam int STAT_W = 2;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 128;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_READ   = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // One stored record, as it sits in a cell of the chain.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DIST_W-1:0] out_distance;
        logic [DIST_W-1:0] none_distance;
        logic [PROT_W-1:0] proto_with;
        logic [PROT_W-1:0] proto_probe;
        logic [PROT_W-1:0] proto_none;
        logic [CYC_W-1:0]  cycles_with;
        logic [CYC_W-1:0]  cycles_none;
        logic [ARR_W-1:0]  arrival;
    } t_rec;

    // Per-cell control driven by the top level.
    typedef struct packed {
        logic             shift;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_ENC  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

>>> rtl/srib_cell.sv
// One cell of the insertion chain: holds a record and takes the new record
// or its lower neighbor's record on an insert. Depends on srib_pkg.
module srib_cell (
    input  logic               i_clk,
    input  logic               i_valid,
    input  srib_pkg::t_cell_ctl i_ctl,
    input  srib_pkg::t_rec     i_new,
    input  srib_pkg::t_rec     i_prev,
    input  logic               i_prev_move,
    output logic               o_move,
    output srib_pkg::t_rec     o_rec
);
    import srib_pkg::*;

    t_rec r_rec;

    // A cell moves when it is empty or holds a strictly greater key, so
    // equal keys stay ahead of the newcomer.
    assign o_move = !i_valid || (r_rec.key > i_ctl.key);
    assign o_rec  = r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && o_move) begin
            r_rec <= i_prev_move ? i_prev : i_new;
        end
    end

endmodule

>>> rtl/srib_enc.sv
// Encoder that turns the one-hot insertion mark of the chain into a slot
// number. Depends on srib_pkg.
module srib_enc (
    input  logic [srib_pkg::DEPTH-1:0] i_hit,
    output logic [srib_pkg::IDX_W-1:0] o_slot
);
    import srib_pkg::*;

    always_comb begin
        o_slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_hit[i]) begin
                o_slot = o_slot | IDX_W'(i);
            end
        end
    end

endmodule

>>> rtl/sorted_record_insertion_buffer.sv
// Top level of the sorted record insertion buffer: control, the chain of
// cells and the result register. Depends on srib_pkg, srib_cell and srib_enc.
//
// Usage. Commands arrive as beats on the s_axis channel; tuser carries the
// function (insert or read) and tdata the record fields and read position.
// Every command gives exactly one result beat on the m_axis channel, with
// the status in tuser and the position, entry count and read-back record in
// tdata.
// Records live in a row of cells kept in ascending key order. On an insert
// every cell compares its key with the new one in the same cycle; cells with
// a greater key, or empty ones, pass their record one place up, and the
// first such cell takes the new record. A read selects one cell by position.
// A command passes execute, encode and then the result register before its
// result is valid. One command is handled at a time: a new command is taken
// only once the result of the last one has been accepted.
// Reset clears the entry count and the control state; the cells need no
// clearing since only positions below the count are ever read.
// When the receiver stalls, the result holds steady in the output register
// and no new command is taken until it has been accepted.
module sorted_record_insertion_buffer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: key_distance, out_distance, none_distance,
    // proto_with, proto_probe, proto_none, cycles_with, cycles_none,
    // read_position.
    input  logic [srib_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Fields: func.
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: position, entry_count, got_key, got_out_distance,
    // got_none_distance, got_proto_with, got_proto_probe, got_proto_none,
    // got_cycles_with, got_cycles_none, arrival_number, zero fill.
    output logic [srib_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields: status.
    output logic [srib_pkg::STAT_W-1:0]     m_axis_tuser
);
    import srib_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_func;
    t_rec                r_new;
    logic [POS_W-1:0]    r_rpos;
    logic [STAT_W-1:0]   r_status;
    logic [DEPTH-1:0]    r_hit;
    t_rec                r_rd;
    logic [OUT_DATA_W-1:0] r_tdata;
    logic [STAT_W-1:0]   r_tuser;

    t_cell_ctl           cell_ctl;
    logic [DEPTH-1:0]    cell_move;
    t_rec                cell_rec [DEPTH];
    logic [DEPTH-1:0]    hit;
    logic [IDX_W-1:0]    enc_slot;
    logic                full;
    logic                rd_ok;
    logic                ins_ok;
    logic [POS_W-1:0]    out_pos;
    t_rec                out_rec;

    assign full   = (r_cnt == CNT_W'(DEPTH));
    assign rd_ok  = CMP_W'(r_rpos) < CMP_W'(r_cnt);
    assign ins_ok = (r_state == S_EXEC) && (r_func == FN_INSERT) && !full;

    assign cell_ctl.shift = ins_ok;
    assign cell_ctl.key   = r_new.key;

    // The chain: each cell sees its lower neighbor's record and move flag.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            srib_cell u_cell (
                .i_clk       (i_clk),
                .i_valid     (CNT_W'(gi) < r_cnt),
                .i_ctl       (cell_ctl),
                .i_new       (r_new),
                .i_prev      (r_new),
                .i_prev_move (1'b0),
                .o_move      (cell_move[gi]),
                .o_rec       (cell_rec[gi])
            );
            assign hit[gi] = cell_move[gi];
        end else begin : g_rest
            srib_cell u_cell (
                .i_clk       (i_clk),
                .i_valid     (CNT_W'(gi) < r_cnt),
                .i_ctl       (cell_ctl),
                .i_new       (r_new),
                .i_prev      (cell_rec[gi-1]),
                .i_prev_move (cell_move[gi-1]),
                .o_move      (cell_move[gi]),
                .o_rec       (cell_rec[gi])
            );
            assign hit[gi] = cell_move[gi] && !cell_move[gi-1];
        end
    end

    srib_enc u_enc (
        .i_hit  (r_hit),
        .o_slot (enc_slot)
    );

    // Result fields assembled in the encode step.
    always_comb begin
        out_rec = '0;
        if (r_func == FN_INSERT) begin
            out_pos = (r_status == ST_OK) ? POS_W'(enc_slot) : '0;
        end else begin
            out_pos = r_rpos;
            if (r_status == ST_OK) begin
                out_rec = r_rd;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ins_ok) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_state = S_ENC;
            end
            S_ENC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Command capture, execute and result registers (payload, no reset).
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_func                <= s_axis_tuser[0];
            r_new.key             <= s_axis_tdata[15:0];
            r_new.out_distance    <= s_axis_tdata[31:16];
            r_new.none_distance   <= s_axis_tdata[47:32];
            r_new.proto_with      <= s_axis_tdata[55:48];
            r_new.proto_probe     <= s_axis_tdata[63:56];
            r_new.proto_none      <= s_axis_tdata[71:64];
            r_new.cycles_with     <= s_axis_tdata[83:72];
            r_new.cycles_none     <= s_axis_tdata[95:84];
            r_new.arrival         <= ARR_W'(r_cnt + CNT_W'(1));
            r_rpos                <= s_axis_tdata[103:96];
        end
        if (r_state == S_EXEC) begin
            r_hit <= hit;
            r_rd  <= cell_rec[IDX_W'(r_rpos)];
            if (r_func == FN_INSERT) begin
                r_status <= full ? ST_FULL : ST_OK;
            end else begin
                r_status <= rd_ok ? ST_OK : ST_RANGE;
            end
        end
        if (r_state == S_ENC) begin
            r_tuser <= r_status;
            r_tdata <= {6'b0, out_rec.arrival, out_rec.cycles_none, out_rec.cycles_with,
                        out_rec.proto_none, out_rec.proto_probe, out_rec.proto_with,
                        out_rec.none_distance, out_rec.out_distance, out_rec.key,
                        ECNT_W'(r_cnt), out_pos};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

    // The count never passes the number of cells.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A successful insert grows the count by exactly one.
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("insert did not advance the count");

    // At most one cell takes the new record.
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ENC |-> $onehot0(r_hit))
        else $error("insertion mark not one-hot");

    // A dropped insert reports slot zero.
    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> m_axis_tdata[7:0] == 8'd0)
        else $error("dropped insert with nonzero position");

endmodule

>>> verif/srib_reply_checker.sv
// Scoreboard for the sorted record insertion buffer: watches both stream channels,
// keeps its own sorted copy of the stored records and compares every result beat.
// Depends on srib_pkg for widths, function and status codes and the record type.
module srib_reply_checker
    import srib_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // Fields from bit 0 up: key_distance, out_distance, none_distance, proto_with,
    // proto_probe, proto_none, cycles_with, cycles_none, read_position.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Fields: func.
    input  logic [0:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // Fields from bit 0 up: position, entry_count, got_key, got_out_distance,
    // got_none_distance, got_proto_with, got_proto_probe, got_proto_none,
    // got_cycles_with, got_cycles_none, arrival_number, zero fill.
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // Fields: status.
    input  logic [STAT_W-1:0]     i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILL_W = OUT_DATA_W - (POS_W + ECNT_W + KEY_W + 2 * DIST_W
                                          + 3 * PROT_W + 2 * CYC_W + ARR_W);

    // Command beat layout, highest field first.
    typedef struct packed {
        logic [POS_W-1:0]  read_position;
        logic [CYC_W-1:0]  cycles_none;
        logic [CYC_W-1:0]  cycles_with;
        logic [PROT_W-1:0] proto_none;
        logic [PROT_W-1:0] proto_probe;
        logic [PROT_W-1:0] proto_with;
        logic [DIST_W-1:0] none_distance;
        logic [DIST_W-1:0] out_distance;
        logic [KEY_W-1:0]  key_distance;
    } command_beat_t;

    // Result beat layout, highest field first.
    typedef struct packed {
        logic [FILL_W-1:0] zero_fill;
        logic [ARR_W-1:0]  arrival;
        logic [CYC_W-1:0]  cycles_none;
        logic [CYC_W-1:0]  cycles_with;
        logic [PROT_W-1:0] proto_none;
        logic [PROT_W-1:0] proto_probe;
        logic [PROT_W-1:0] proto_with;
        logic [DIST_W-1:0] none_distance;
        logic [DIST_W-1:0] out_distance;
        logic [KEY_W-1:0]  key;
        logic [ECNT_W-1:0] entry_count;
        logic [POS_W-1:0]  position;
    } reply_beat_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [ECNT_W-1:0] entry_count;
        t_rec              rec;
    } buffer_reply_t;

    t_rec          sorted_records [DEPTH];
    int unsigned   fill_level;
    buffer_reply_t awaited_replies [$];
    buffer_reply_t want;
    reply_beat_t   got;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Applies one command to the shadow buffer and returns the reply it must give.
    function automatic buffer_reply_t apply_command(input logic fn,
                                                    input command_beat_t cmd);
        buffer_reply_t r;
        t_rec          fresh;
        int unsigned   slot;
        int unsigned   k;
        r.status      = ST_OK;
        r.position    = '0;
        r.entry_count = '0;
        r.rec         = '0;
        if (fn == FN_INSERT) begin
            if (fill_level >= DEPTH) begin
                r.status      = ST_FULL;
                r.entry_count = ECNT_W'(fill_level);
            end else begin
                // Equal keys go behind the ones already stored.
                slot = 0;
                while (slot < fill_level && sorted_records[slot].key <= cmd.key_distance)
                    slot++;
                for (k = fill_level; k > slot; k--)
                    sorted_records[k] = sorted_records[k-1];
                fill_level++;
                fresh.key           = cmd.key_distance;
                fresh.out_distance  = cmd.out_distance;
                fresh.none_distance = cmd.none_distance;
                fresh.proto_with    = cmd.proto_with;
                fresh.proto_probe   = cmd.proto_probe;
                fresh.proto_none    = cmd.proto_none;
                fresh.cycles_with   = cmd.cycles_with;
                fresh.cycles_none   = cmd.cycles_none;
                fresh.arrival       = ARR_W'(fill_level);
                sorted_records[slot] = fresh;
                r.position    = POS_W'(slot);
                r.entry_count = ECNT_W'(fill_level);
            end
        end else begin
            r.position    = cmd.read_position;
            r.entry_count = ECNT_W'(fill_level);
            if (cmd.read_position >= fill_level)
                r.status = ST_RANGE;
            else
                r.rec = sorted_records[cmd.read_position];
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_level = 0;
            awaited_replies.delete();
            o_pending = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                awaited_replies.push_back(apply_command(i_s_tuser[0], i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                o_checked++;
                if (awaited_replies.size() == 0) begin
                    $error("result beat arrived with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("status", want.status, i_m_tuser);
                    compare_field("position", want.position, got.position);
                    compare_field("entry_count", want.entry_count, got.entry_count);
                    compare_field("got_key", want.rec.key, got.key);
                    compare_field("got_out_distance", want.rec.out_distance,
                                  got.out_distance);
                    compare_field("got_none_distance", want.rec.none_distance,
                                  got.none_distance);
                    compare_field("got_proto_with", want.rec.proto_with, got.proto_with);
                    compare_field("got_proto_probe", want.rec.proto_probe,
                                  got.proto_probe);
                    compare_field("got_proto_none", want.rec.proto_none, got.proto_none);
                    compare_field("got_cycles_with", want.rec.cycles_with,
                                  got.cycles_with);
                    compare_field("got_cycles_none", want.rec.cycles_none,
                                  got.cycles_none);
                    compare_field("arrival_number", want.rec.arrival, got.arrival);
                    compare_field("zero fill", '0, got.zero_fill);
                end
            end
            o_pending = awaited_replies.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the sorted record insertion buffer: clock, reset, command
// stimulus, receiver back-pressure and the final verdict. Depends on srib_pkg,
// the block itself and srib_reply_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import srib_pkg::*;

    localparam int ITEMS_PER_PHASE = 435;
    localparam int HOLD_CYCLES     = 300;
    localparam int LIMIT_CYCLES    = 250000;
    localparam int DRAIN_CYCLES    = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;

    int fail_count;
    int replies_pending;
    int replies_checked;

    // Traffic knobs and stimulus bookkeeping.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int unsigned inserts_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned reads_beyond = 0;
    int          cycle_count;

    sorted_record_insertion_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    srib_reply_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (replies_pending),
        .o_checked    (replies_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: a pending hold-off wins over the random stall roll.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run timed out after %0d cycles", LIMIT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_command(
        input logic [KEY_W-1:0] key, input logic [DIST_W-1:0] od,
        input logic [DIST_W-1:0] nd, input logic [PROT_W-1:0] pw,
        input logic [PROT_W-1:0] pp, input logic [PROT_W-1:0] pn,
        input logic [CYC_W-1:0] cw, input logic [CYC_W-1:0] cn,
        input logic [POS_W-1:0] rp);
        return {rp, cn, cw, pn, pp, pw, nd, od, key};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_record(input logic [KEY_W-1:0] key,
                                                           input logic [POS_W-1:0] rp);
        return pack_command(key, DIST_W'($urandom), DIST_W'($urandom),
                            PROT_W'($urandom), PROT_W'($urandom), PROT_W'($urandom),
                            CYC_W'($urandom), CYC_W'($urandom), rp);
    endfunction

    // Many keys come from a handful of values so that ties are frequent.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return KEY_W'($urandom_range(5)) << 12;
            default:    return KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input int unsigned stored);
        case ($urandom_range(9))
            0, 1:    return POS_W'($urandom_range(255));
            2:       return (stored <= 255) ? POS_W'(stored) : POS_W'($urandom_range(255));
            3:       return (stored > 0) ? POS_W'(stored - 1) : '0;
            default: return (stored > 0) ? POS_W'($urandom_range(stored - 1))
                                         : POS_W'($urandom_range(255));
        endcase
    endfunction

    // Offers one beat, with random idle cycles ahead of it, and returns on the
    // falling edge after it was taken.
    task automatic send_command(input logic fn, input logic [IN_DATA_W-1:0] payload);
        int unsigned stored;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        stored = (inserts_sent > DEPTH) ? DEPTH : inserts_sent;
        if (fn == FN_INSERT) begin
            inserts_sent++;
        end else begin
            reads_sent++;
            if (payload[IN_DATA_W-1 -: POS_W] >= stored)
                reads_beyond++;
        end
        @(negedge i_clk);
    endtask

    task automatic random_command();
        int unsigned stored;
        stored = (inserts_sent > DEPTH) ? DEPTH : inserts_sent;
        if ($urandom_range(99) < ((stored < DEPTH) ? 35 : 20))
            send_command(FN_INSERT, random_record(pick_key(), POS_W'($urandom)));
        else
            send_command(FN_READ, random_record(KEY_W'($urandom), pick_position(stored)));
    endtask

    // Knobs change on a rising edge so the receiver never races them.
    task automatic phase_switch(input int send_pct, input int recv_pct, input int hold);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        @(negedge i_clk);
    endtask

    initial begin
        int ph;
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads of an empty buffer, extreme keys and payloads, ties at
        // both ends and in the middle, reads up to and one past the fill level.
        send_command(FN_READ, pack_command('0, '0, '0, '0, '0, '0, '0, '0, 8'd0));
        send_command(FN_READ, pack_command('1, '1, '1, '1, '1, '1, '1, '1, 8'hFF));
        send_command(FN_INSERT, pack_command(16'h8000, '1, '1, '1, '1, '1, '1, '1, 8'h00));
        send_command(FN_INSERT, pack_command(16'h0000, '0, '0, '0, '0, '0, '0, '0, 8'hFF));
        send_command(FN_INSERT, pack_command(16'hFFFF, '1, '1, '1, '1, '1, '1, '1, 8'h00));
        send_command(FN_INSERT, random_record(16'h8000, 8'h00));
        send_command(FN_INSERT, random_record(16'h8000, 8'h00));
        send_command(FN_INSERT, random_record(16'h0000, 8'h00));
        send_command(FN_INSERT, random_record(16'hFFFF, 8'h00));
        for (n = 0; n <= 7; n++)
            send_command(FN_READ, random_record(KEY_W'($urandom), POS_W'(n)));
        send_command(FN_READ, random_record('1, 8'hFF));

        // Random traffic in four back-pressure phases; the buffer fills up in
        // the first half, after which inserts are dropped as full.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       phase_switch(0, 0, 0);
                1:       phase_switch(65, 0, 0);
                2:       phase_switch(0, 65, 0);
                default: phase_switch(28, 28, 0);
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long receiver hold-off while commands keep coming.
                if (ph == 0 && n == ITEMS_PER_PHASE / 2)
                    phase_switch(0, 0, HOLD_CYCLES);
                random_command();
            end
        end
        s_axis_tvalid <= 1'b0;

        wait (replies_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts, %0d of them into a full buffer, and %0d reads,",
                 inserts_sent, (inserts_sent > DEPTH) ? inserts_sent - DEPTH : 0,
                 reads_sent);
        $display("%0d of which were at or past the fill level; %0d results checked.",
                 reads_beyond, replies_checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
